/* rtl/opfla_pkg.sv */
// Package for the object pool free list allocator.
// Holds pool sizing constants, pointer types, request and result structs and codes.
// No dependencies.
package opfla_pkg;

  // Number of slots in the pool.
  localparam int POOL_SIZE = 64;
  // A pointer holds a slot number or the null value POOL_SIZE.
  localparam int PTR_W = $clog2(POOL_SIZE + 1);
  // Address width of the link store.
  localparam int ADDR_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  // Width of the slot fields on the ports.
  localparam int IDX_W = 6;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam ptr_t SLOT_NULL = PTR_W'(POOL_SIZE);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] slot_index;
  } request_t;

  typedef struct packed {
    logic [IDX_W-1:0] granted_index;
    status_t          status;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_WALK,
    S_FIX
  } state_t;

endpackage

/* rtl/opfla_ram.sv */
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
module opfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  clk,
  we,
  waddr,
  wdata,
  raddr,
  rdata
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  input  logic             clk;
  input  logic             we;
  input  logic [AW-1:0]    waddr;
  input  logic [WIDTH-1:0] wdata;
  input  logic [AW-1:0]    raddr;
  output logic [WIDTH-1:0] rdata;

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; a read of the entry being written returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/object_pool_free_list_allocator_top.sv */
// Object pool allocator: free list and active list sharing one link store RAM.
// Allocate pops the free head in S_ALLOC and strobes its result from a register; with the
// pool empty it stays idle and strobes in the next cycle. Free walks one link per cycle,
// adds the S_FIX state when the slot is mid-list, and reports a miss at the end of the
// list or after POOL_SIZE links. Results strobe one cycle; the receiver cannot stall.
// Reset clears the lists at once: per-entry valid bits make unwritten links read as i+1.
module object_pool_free_list_allocator_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  opfla_pkg::request_t request,
  output logic               done,
  output opfla_pkg::result_t  result
);
  import opfla_pkg::*;

  state_t           state, state_next;
  ptr_t             free_head, free_head_next;
  ptr_t             active_head, active_head_next;
  ptr_t             cur, cur_next;
  ptr_t             prev, prev_next;
  ptr_t             steps, steps_next;
  ptr_t             nxt, nxt_next;
  logic [IDX_W-1:0] want, want_next;
  logic             done_next;
  result_t          result_next;

  logic             ram_we;
  addr_t            ram_waddr;
  ptr_t             ram_wdata;
  addr_t            ram_raddr;
  ptr_t             ram_rdata;
  addr_t            raddr_q;
  logic             rvalid_q;
  logic [POOL_SIZE-1:0] link_valid;
  ptr_t             link_rd;
  logic             cur_match;

  // Slot number reduced to the port width.
  function automatic logic [IDX_W-1:0] to_idx(input ptr_t v);
    logic [PTR_W+IDX_W-1:0] wide;
    wide = (PTR_W + IDX_W)'(v);
    return wide[IDX_W-1:0];
  endfunction

  opfla_ram #(
    .WIDTH(PTR_W),
    .DEPTH(POOL_SIZE)
  ) u_link_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // An entry never written since reset holds its reset link, the next slot.
  assign link_rd = rvalid_q ? ram_rdata : (PTR_W'(raddr_q) + PTR_W'(1));

  assign cur_match = ((PTR_W + IDX_W)'(cur) == (PTR_W + IDX_W)'(want));

  assign busy = (state != S_IDLE);

  // Valid bits and the read-side tags that go with the RAM output.
  always_ff @(posedge clk) begin
    if (rst) begin
      link_valid <= '0;
    end else if (ram_we) begin
      link_valid[ram_waddr] <= 1'b1;
    end
    raddr_q  <= ram_raddr;
    rvalid_q <= link_valid[ram_raddr];
  end

  // Control and list registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      free_head   <= '0;
      active_head <= SLOT_NULL;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      free_head   <= free_head_next;
      active_head <= active_head_next;
      done        <= done_next;
    end
  end

  // Walk and result payload registers.
  always_ff @(posedge clk) begin
    cur    <= cur_next;
    prev   <= prev_next;
    steps  <= steps_next;
    nxt    <= nxt_next;
    want   <= want_next;
    result <= result_next;
  end

  // Sequencer: allocate, walk the active list, unlink.
  always_comb begin
    state_next       = state;
    free_head_next   = free_head;
    active_head_next = active_head;
    cur_next         = cur;
    prev_next        = prev;
    steps_next       = steps;
    nxt_next         = nxt;
    want_next        = want;
    done_next        = 1'b0;
    result_next      = result;
    ram_we           = 1'b0;
    ram_waddr        = '0;
    ram_wdata        = '0;
    ram_raddr        = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          if (request.op == OP_ALLOC) begin
            if (free_head >= SLOT_NULL) begin
              done_next   = 1'b1;
              result_next = '{granted_index: '0, status: ST_EMPTY};
            end else begin
              ram_raddr  = free_head[ADDR_W-1:0];
              state_next = S_ALLOC;
            end
          end else begin
            cur_next   = active_head;
            prev_next  = SLOT_NULL;
            steps_next = '0;
            want_next  = request.slot_index;
            ram_raddr  = active_head[ADDR_W-1:0];
            state_next = S_WALK;
          end
        end
      end

      S_ALLOC: begin
        // Pop the free head and push it onto the active list.
        free_head_next   = link_rd;
        ram_we           = 1'b1;
        ram_waddr        = free_head[ADDR_W-1:0];
        ram_wdata        = active_head;
        active_head_next = free_head;
        done_next        = 1'b1;
        result_next      = '{granted_index: to_idx(free_head), status: ST_OK};
        state_next       = S_IDLE;
      end

      S_WALK: begin
        // The link of the current slot is on the RAM output in this cycle.
        if (cur >= SLOT_NULL || steps >= SLOT_NULL) begin
          done_next   = 1'b1;
          result_next = '{granted_index: '0, status: ST_NOT_FOUND};
          state_next  = S_IDLE;
        end else if (cur_match) begin
          ram_we         = 1'b1;
          ram_waddr      = cur[ADDR_W-1:0];
          ram_wdata      = free_head;
          free_head_next = cur;
          done_next      = 1'b1;
          result_next    = '{granted_index: to_idx(cur), status: ST_OK};
          if (prev >= SLOT_NULL) begin
            active_head_next = link_rd;
            state_next       = S_IDLE;
          end else begin
            nxt_next   = link_rd;
            state_next = S_FIX;
          end
        end else begin
          prev_next  = cur;
          cur_next   = link_rd;
          steps_next = steps + PTR_W'(1);
          ram_raddr  = link_rd[ADDR_W-1:0];
        end
      end

      S_FIX: begin
        // Close the gap left by the unlinked slot.
        ram_we     = 1'b1;
        ram_waddr  = prev[ADDR_W-1:0];
        ram_wdata  = nxt;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/opfla_checker.sv */
// Port-level checker for the object pool allocator, bound to the top level.
// Depends on opfla_pkg and object_pool_free_list_allocator_top.
module opfla_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input opfla_pkg::request_t request,
  input logic               done,
  input opfla_pkg::result_t  result
);
  import opfla_pkg::*;

  // Reset leaves the block idle with no result pending.
  a_reset_idle: assert property (@(posedge clk) rst |=> (!busy && !done))
    else $error("block not idle after reset");

  // An accepted request either keeps the block busy or reports at once.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted request made no progress");

  // Status carries only defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == ST_OK || result.status == ST_EMPTY ||
              result.status == ST_NOT_FOUND))
    else $error("undefined status code");

  // A failed request reports slot zero.
  a_fail_index: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |-> (result.granted_index == '0))
    else $error("failed request reported a slot");

endmodule

bind object_pool_free_list_allocator_top opfla_checker u_opfla_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .request(request),
  .done   (done),
  .result (result)
);

/* tb/object_pool_free_list_allocator_checker.sv */
// Checker for the object pool free list allocator: watches the request and result channels.
// Keeps its own copy of the free and active lists and compares every strobed result.
// Depends on opfla_pkg.
module object_pool_free_list_allocator_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  opfla_pkg::request_t request,
  input  logic                done,
  input  opfla_pkg::result_t  result,
  output int                  errors,
  output int                  pending
);
  import opfla_pkg::*;

  // Shadow of the shared link store and the two list heads.
  ptr_t    link_tbl [POOL_SIZE];
  ptr_t    free_hd;
  ptr_t    active_hd;
  result_t owed_results [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Applies one request to the shadow lists and returns the result it should give.
  function automatic result_t pool_update(input request_t req);
    result_t res;
    ptr_t    cur;
    ptr_t    prev;
    ptr_t    nxt;
    int      steps;
    logic    found;
    res.granted_index = '0;
    res.status        = ST_OK;
    if (req.op == OP_ALLOC) begin
      if (free_hd >= POOL_SIZE) begin
        res.status = ST_EMPTY;
      end else begin
        cur               = free_hd;
        free_hd           = link_tbl[cur];
        link_tbl[cur]     = active_hd;
        active_hd         = cur;
        res.granted_index = IDX_W'(cur);
      end
    end else begin
      // Walk the active list from its head, one link at a time.
      cur        = active_hd;
      prev       = SLOT_NULL;
      steps      = 0;
      found      = 1'b0;
      res.status = ST_NOT_FOUND;
      while (!found && cur < POOL_SIZE && steps < POOL_SIZE) begin
        if (cur == ptr_t'(req.slot_index)) begin
          nxt = link_tbl[cur];
          if (prev >= POOL_SIZE) begin
            active_hd = nxt;
          end else begin
            link_tbl[prev] = nxt;
          end
          link_tbl[cur]     = free_hd;
          free_hd           = cur;
          res.granted_index = IDX_W'(cur);
          res.status        = ST_OK;
          found             = 1'b1;
        end else begin
          prev  = cur;
          cur   = link_tbl[cur];
          steps = steps + 1;
        end
      end
    end
    return res;
  endfunction

  // Sample both channels at each rising edge, results before new requests.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int i = 0; i < POOL_SIZE; i++) begin
        link_tbl[i] = ptr_t'(i + 1);
      end
      free_hd   = '0;
      active_hd = SLOT_NULL;
      owed_results.delete();
    end else begin
      if (done) begin
        if (owed_results.size() == 0) begin
          $error("result strobed with no request outstanding: granted_index %0d status %0d",
                 result.granted_index, result.status);
          errors = errors + 1;
        end else begin
          want = owed_results.pop_front();
          if (result.granted_index !== want.granted_index) begin
            $error("granted_index: expected %0d, got %0d",
                   want.granted_index, result.granted_index);
            errors = errors + 1;
          end
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            errors = errors + 1;
          end
        end
      end
      if (start && !busy) begin
        owed_results.push_back(pool_update(request));
      end
    end
    pending = owed_results.size();
  end

endmodule

/* tb/object_pool_free_list_allocator_top_test.sv */
// Testbench top for the object pool free list allocator: drives allocate and free requests.
// Directed list walks first, then random fill, drain and mixed phases with random idling.
// Depends on opfla_pkg, object_pool_free_list_allocator_top and the checker module.
module object_pool_free_list_allocator_top_test;
  import opfla_pkg::*;

  logic     clk     = 1'b0;
  logic     rst     = 1'b1;
  logic     start   = 1'b0;
  request_t request = '0;
  logic     busy;
  logic     done;
  result_t  result;
  int       errors;
  int       pending;
  int       sent;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  object_pool_free_list_allocator_top DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  object_pool_free_list_allocator_checker checker_inst (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result),
    .errors  (errors),
    .pending (pending)
  );

  // Present one request, hold it until accepted, then idle for the given cycles.
  // With no idle cycles start stays high for the next request.
  task automatic issue(input op_t op, input logic [IDX_W-1:0] idx, input int gap);
    request_t req;
    req.op         = op;
    req.slot_index = idx;
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    sent = sent + 1;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  function automatic int idle_gap(input logic burst);
    return burst ? 0 : $urandom_range(0, 10);
  endfunction

  initial begin
    int   kind;
    int   plen;
    int   alloc_pct;
    logic burst;
    sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty active list, head, middle and tail removal, double free.
    issue(OP_FREE,  6'd0,  idle_gap(1'b0));
    issue(OP_ALLOC, 6'd63, idle_gap(1'b0));
    issue(OP_ALLOC, 6'd0,  idle_gap(1'b0));
    issue(OP_ALLOC, 6'd42, idle_gap(1'b0));
    issue(OP_FREE,  6'd1,  idle_gap(1'b0));
    issue(OP_FREE,  6'd0,  idle_gap(1'b0));
    issue(OP_FREE,  6'd2,  idle_gap(1'b0));
    issue(OP_FREE,  6'd2,  idle_gap(1'b0));
    issue(OP_FREE,  6'd63, idle_gap(1'b0));
    for (int i = 0; i < 6; i++) begin
      issue(OP_ALLOC, IDX_W'($urandom_range(0, 63)), idle_gap(1'b1));
    end
    issue(OP_FREE,  6'd5,  0);
    issue(OP_FREE,  6'd0,  0);
    issue(OP_FREE,  6'd3,  0);
    issue(OP_ALLOC, 6'd21, 0);
    issue(OP_FREE,  6'd63, idle_gap(1'b0));
    drain_results();

    // Random phases: fill towards an empty pool, drain it, or mix both.
    while (sent < 750) begin
      kind  = $urandom_range(0, 2);
      plen  = $urandom_range(30, 90);
      burst = ($urandom_range(0, 3) == 0);
      case (kind)
        0: begin
          alloc_pct = 90;
        end
        1: begin
          alloc_pct = 15;
        end
        default: begin
          alloc_pct = 50;
        end
      endcase
      for (int i = 0; i < plen; i++) begin
        if ($urandom_range(1, 100) <= alloc_pct) begin
          issue(OP_ALLOC, IDX_W'($urandom_range(0, 63)), idle_gap(burst));
        end else begin
          issue(OP_FREE, IDX_W'($urandom_range(0, 63)), idle_gap(burst));
        end
      end
      if ($urandom_range(0, 2) == 0) begin
        drain_results();
      end
    end

    // Wait for the last results, then keep watching for any stray strobe before the verdict.
    drain_results();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("object_pool_free_list_allocator_top regression: pass");
    end else begin
      $display("object_pool_free_list_allocator_top regression: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5000000;
    $display("object_pool_free_list_allocator_top regression: fail");
    $finish;
  end

endmodule
